/* hw/rtl/crs_enc_pkg.sv */
package crs_enc_pkg;

	// default sizing
	localparam int MAX_SYMBOL_BYTES_DEF = 2048;
	localparam int MAX_SOURCES_DEF      = 256;
	localparam int FIELD_POLY_DEF       = 285;

	// field widths
	localparam int SRC_W    = 8;
	localparam int OFF_W    = 11;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 9;
	localparam int SB_W     = 12;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPAIR_INDEX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BYTES = 2'd2;

	// reset values of the registers
	localparam logic [CNT_W-1:0]  SOURCE_COUNT_RST = 9'd1;
	localparam logic [SRC_W-1:0]  REPAIR_INDEX_RST = 8'd0;
	localparam logic [SB_W-1:0]   SYMBOL_BYTES_RST = 12'd1024;

	// clamped settings handed from the register file to the datapath
	typedef struct packed {
		logic [CNT_W-1:0] k;         // effective source count
		logic [SRC_W-1:0] point;     // (k + repair_index) mod 256
		logic [SRC_W-1:0] last_src;  // k - 1
		logic [SB_W-1:0]  sb;        // effective symbol bytes
		logic [SB_W-1:0]  last_off;  // sb - 1
	} crs_cfg_t;

	typedef logic [BYTE_W-1:0] gf_tbl_t [256];

	// gf(2^8) product, shift-and-add with reduction by poly
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] poly);
		logic [8:0] x;
		logic [7:0] r;
		x = {1'b0, a};
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				r = r ^ x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8])
				x = x ^ poly;
		end
		return r;
	endfunction

	// inverse table, a^254 per entry; entry 0 yields 0
	function automatic gf_tbl_t gf_inv_table(input logic [8:0] poly);
		gf_tbl_t    t;
		logic [7:0] res;
		logic [7:0] base;
		logic [7:0] e;
		for (int a = 0; a < 256; a++) begin
			res  = 8'h01;
			base = 8'(a);
			e    = 8'd254;
			for (int j = 0; j < 8; j++) begin
				if (e[j])
					res = gf_mul(res, base, poly);
				base = gf_mul(base, base, poly);
			end
			t[a] = res;
		end
		return t;
	endfunction

endpackage

/* hw/rtl/cauchy_rs_repair_encoder.sv */
// cauchy reed-solomon repair encoder, gf(256), one repair symbol at a time
//
// channels: s_* carries source bytes in source-major order, m_* carries the
// finished repair bytes, cfg_* writes source_count (index 0), repair_index
// (index 1) and symbol_bytes (index 2). configure only while idle.
// each source byte is scaled by inv(((k + repair_index) mod 256) ^ source)
// and folded into a byte store at its offset; source 0 overwrites the entry.
// bytes of the last source (k-1) each return the finished repair byte for
// their offset, with m_tlast on offset symbol_bytes-1. other bytes and bytes
// outside k or symbol_bytes return nothing.
// throughput: one byte per cycle unless a result waits at a held output, set
// by the single read-modify-write of the store; the write port and the read
// port work in the same cycle, with a forward path for back-to-back bytes at
// one offset. the path from input to m_tvalid runs through table lookup and
// store read, multiply and write back, and the output register.
// reset clears the pipeline and restores the register defaults; the store is
// not cleared, so source 0 must be sent before the other sources.
// a stalled m_tready holds the whole pipeline, and drops s_tready, only when a
// result is waiting behind the held output.
module cauchy_rs_repair_encoder #(
	parameter int MAX_SYMBOL_BYTES = crs_enc_pkg::MAX_SYMBOL_BYTES_DEF,
	parameter int MAX_SOURCES      = crs_enc_pkg::MAX_SOURCES_DEF,
	parameter int FIELD_POLY       = crs_enc_pkg::FIELD_POLY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// source byte stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [crs_enc_pkg::S_DATA_W-1:0]    s_tdata,   // source_index, byte_offset, data_byte
	// repair byte stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [crs_enc_pkg::M_DATA_W-1:0]    m_tdata,   // repair_byte, out_offset
	output logic                                m_tlast,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crs_enc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crs_enc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = (MAX_SYMBOL_BYTES > 1) ? $clog2(MAX_SYMBOL_BYTES) : 1;
	localparam crs_enc_pkg::gf_tbl_t INV_TBL = crs_enc_pkg::gf_inv_table(9'(FIELD_POLY));

	crs_enc_pkg::crs_cfg_t cfg;

	// unpacked input fields
	logic [crs_enc_pkg::SRC_W-1:0]  in_src;
	logic [crs_enc_pkg::OFF_W-1:0]  in_off;
	logic [crs_enc_pkg::BYTE_W-1:0] in_data;
	logic                           in_ok;

	// stage 1: coefficient lookup and store read
	logic                           v_s1;
	logic [crs_enc_pkg::SRC_W-1:0]  idx_s1;
	logic [AW-1:0]                  addr_s1;
	logic [crs_enc_pkg::OFF_W-1:0]  off_s1;
	logic [crs_enc_pkg::BYTE_W-1:0] data_s1;
	logic                           first_s1;
	logic                           emit_s1;
	logic                           last_s1;

	// stage 2: multiply, fold and write back
	logic                           v_s2;
	logic [crs_enc_pkg::BYTE_W-1:0] coef_s2;
	logic [AW-1:0]                  addr_s2;
	logic [crs_enc_pkg::OFF_W-1:0]  off_s2;
	logic [crs_enc_pkg::BYTE_W-1:0] data_s2;
	logic                           first_s2;
	logic                           emit_s2;
	logic                           last_s2;
	logic                           fwd_s2;
	logic [crs_enc_pkg::BYTE_W-1:0] fwd_data_s2;

	logic [crs_enc_pkg::BYTE_W-1:0] rd_data;
	logic [crs_enc_pkg::BYTE_W-1:0] prod;
	logic [crs_enc_pkg::BYTE_W-1:0] old_byte;
	logic [crs_enc_pkg::BYTE_W-1:0] new_byte;

	// output register
	logic                           out_valid_q;
	logic [crs_enc_pkg::BYTE_W-1:0] out_byte_q;
	logic [crs_enc_pkg::OFF_W-1:0]  out_off_q;
	logic                           out_last_q;

	logic adv;

	assign cfg_ready = 1'b1;

	crs_enc_cfg #(
		.MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES),
		.MAX_SOURCES      (MAX_SOURCES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// pipeline moves unless a result in stage 2 has nowhere to go
	assign adv      = !(v_s2 && emit_s2 && out_valid_q && !m_tready);
	assign s_tready = adv;

	assign in_src  = s_tdata[7:0];
	assign in_off  = s_tdata[18:8];
	assign in_data = s_tdata[26:19];

	// bytes outside the source count or symbol length are dropped here
	assign in_ok = ({1'b0, in_src} < cfg.k) && ({1'b0, in_off} < cfg.sb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= s_tvalid && in_ok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= cfg.point ^ in_src;
			addr_s1  <= AW'(in_off);
			off_s1   <= in_off;
			data_s1  <= in_data;
			first_s1 <= (in_src == '0);
			emit_s1  <= (in_src == cfg.last_src);
			last_s1  <= ({1'b0, in_off} == cfg.last_off);
		end
	end

	crs_enc_ram #(
		.DEPTH (MAX_SYMBOL_BYTES),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (addr_s1),
		.rd_data (rd_data),
		.wr_en   (adv && v_s2),
		.wr_addr (addr_s2),
		.wr_data (new_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s2     <= INV_TBL[idx_s1];
			addr_s2     <= addr_s1;
			off_s2      <= off_s1;
			data_s2     <= data_s1;
			first_s2    <= first_s1;
			emit_s2     <= emit_s1;
			last_s2     <= last_s1;
			// the store read misses a write landing in the same cycle
			fwd_s2      <= v_s2 && (addr_s2 == addr_s1);
			fwd_data_s2 <= new_byte;
		end
	end

	assign prod     = crs_enc_pkg::gf_mul(coef_s2, data_s2, 9'(FIELD_POLY));
	assign old_byte = fwd_s2 ? fwd_data_s2 : rd_data;
	assign new_byte = first_s2 ? prod : (old_byte ^ prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && v_s2 && emit_s2)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && emit_s2) begin
			out_byte_q <= new_byte;
			out_off_q  <= off_s2;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_off_q, out_byte_q};
	assign m_tlast  = out_last_q;

endmodule

/* hw/rtl/crs_enc_cfg.sv */
module crs_enc_cfg #(
	parameter int MAX_SYMBOL_BYTES = crs_enc_pkg::MAX_SYMBOL_BYTES_DEF,
	parameter int MAX_SOURCES      = crs_enc_pkg::MAX_SOURCES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [crs_enc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [crs_enc_pkg::CFG_DATA_W-1:0] wr_data,
	output crs_enc_pkg::crs_cfg_t              cfg
);

	logic [crs_enc_pkg::CNT_W-1:0] source_count_q;
	logic [crs_enc_pkg::SRC_W-1:0] repair_index_q;
	logic [crs_enc_pkg::SB_W-1:0]  symbol_bytes_q;

	logic [crs_enc_pkg::CNT_W-1:0] k_eff;
	logic [crs_enc_pkg::SB_W-1:0]  sb_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_count_q <= crs_enc_pkg::SOURCE_COUNT_RST;
			repair_index_q <= crs_enc_pkg::REPAIR_INDEX_RST;
			symbol_bytes_q <= crs_enc_pkg::SYMBOL_BYTES_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				crs_enc_pkg::REG_SOURCE_COUNT: source_count_q <= wr_data[crs_enc_pkg::CNT_W-1:0];
				crs_enc_pkg::REG_REPAIR_INDEX: repair_index_q <= wr_data[crs_enc_pkg::SRC_W-1:0];
				crs_enc_pkg::REG_SYMBOL_BYTES: symbol_bytes_q <= wr_data;
				default: ;
			endcase
		end
	end

	// zero and oversize settings clamp into range
	always_comb begin
		if (source_count_q == '0)
			k_eff = 9'd1;
		else if (source_count_q > 9'(MAX_SOURCES))
			k_eff = 9'(MAX_SOURCES);
		else
			k_eff = source_count_q;

		if (symbol_bytes_q == '0)
			sb_eff = 12'd1;
		else if (17'(symbol_bytes_q) > 17'(MAX_SYMBOL_BYTES))
			sb_eff = 12'(MAX_SYMBOL_BYTES);
		else
			sb_eff = symbol_bytes_q;
	end

	always_comb begin
		cfg.k        = k_eff;
		cfg.point    = 8'(k_eff + {1'b0, repair_index_q});
		cfg.last_src = 8'(k_eff - 9'd1);
		cfg.sb       = sb_eff;
		cfg.last_off = sb_eff - 12'd1;
	end

endmodule

/* hw/rtl/crs_enc_ram.sv */
module crs_enc_ram #(
	parameter int DEPTH = crs_enc_pkg::MAX_SYMBOL_BYTES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic [crs_enc_pkg::BYTE_W-1:0] rd_data,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [crs_enc_pkg::BYTE_W-1:0] wr_data
);

	logic [crs_enc_pkg::BYTE_W-1:0] mem [DEPTH];

	// read returns the old contents on a same-cycle write
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule
